### rtl/core/hmmf_pkg.sv
// Package for the log-domain HMM forward unit: types, constants, log arithmetic.
// No dependencies.
package hmmf_pkg;
  localparam int DEF_MAX_STATES  = 8;
  localparam int DEF_NUM_SYMBOLS = 16;
  localparam int VAL_W = 32;
  localparam int IDX_W = 7;
  localparam int SYM_W = 4;
  localparam int CFG_W = 4;

  localparam logic signed [VAL_W-1:0] LOG_ZERO  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] LOG_FLOOR = {1'b1, {(VAL_W-2){1'b0}}, 1'b1};
  localparam logic signed [VAL_W-1:0] LOG_TOP   = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_WR_INIT  = 2'd0,
    OP_WR_TRANS = 2'd1,
    OP_WR_EMIT  = 2'd2,
    OP_OBSERVE  = 2'd3
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic ld_sym;     // symbol register <= input symbol
    logic ld_acc;     // acc <= LOG_ZERO
    logic acc_step;   // acc <= log_add(acc, operand)
    logic use_prod;   // operand is alpha_prev*trans, else alpha_cur
    logic wr_first;   // alpha_cur[i] <= init*emit
    logic wr_alpha;   // alpha_cur[i] <= acc*emit
    logic copy_prev;  // alpha_prev <= alpha_cur
    logic ld_out;     // output register <= acc
  } dp_cmd_t;

  function automatic logic signed [VAL_W-1:0] sat33(input logic signed [VAL_W:0] v);
    logic signed [VAL_W:0] fl, tp;
    fl = {LOG_FLOOR[VAL_W-1], LOG_FLOOR};
    tp = {1'b0, LOG_TOP};
    if (v < fl) return LOG_FLOOR;
    if (v > tp) return LOG_TOP;
    return v[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] log_mul(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    if (a == LOG_ZERO || b == LOG_ZERO) return LOG_ZERO;
    return sat33({a[VAL_W-1], a} + {b[VAL_W-1], b});
  endfunction

  function automatic logic [16:0] corr_rom(input logic [4:0] k);
    logic [16:0] r;
    case (k)
      5'd0: r = 17'd45426;  5'd1: r = 17'd37745;  5'd2: r = 17'd31069;
      5'd3: r = 17'd25354;  5'd4: r = 17'd20530;  5'd5: r = 17'd16510;
      5'd6: r = 17'd13200;  5'd7: r = 17'd10500;  5'd8: r = 17'd8318;
      5'd9: r = 17'd6567;   5'd10: r = 17'd5170;  5'd11: r = 17'd4061;
      5'd12: r = 17'd3184;  5'd13: r = 17'd2493;  5'd14: r = 17'd1950;
      5'd15: r = 17'd1523;  5'd16: r = 17'd1189;  5'd17: r = 17'd928;
      5'd18: r = 17'd724;   5'd19: r = 17'd565;   5'd20: r = 17'd440;
      5'd21: r = 17'd343;   5'd22: r = 17'd267;   5'd23: r = 17'd208;
      5'd24: r = 17'd162;   5'd25: r = 17'd126;   5'd26: r = 17'd98;
      5'd27: r = 17'd77;    5'd28: r = 17'd60;    5'd29: r = 17'd47;
      5'd30: r = 17'd36;    default: r = 17'd28;
    endcase
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] log_add(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] hi, d;
    logic [16:0] c;
    if (a == LOG_ZERO) return b;
    if (b == LOG_ZERO) return a;
    hi = (a > b) ? {a[VAL_W-1], a} : {b[VAL_W-1], b};
    d  = (a > b) ? ({a[VAL_W-1], a} - {b[VAL_W-1], b}) : ({b[VAL_W-1], b} - {a[VAL_W-1], a});
    c  = (d < 33'sd524288) ? corr_rom(d[18:14]) : 17'd0;
    return sat33(hi + {16'd0, c});
  endfunction
endpackage

### rtl/core/hmmf_if.sv
// Valid/ready channel interfaces for the HMM forward unit.
// Depends on hmmf_pkg.
interface hmmf_in_if import hmmf_pkg::*; ();
  logic valid, ready;
  logic [1:0] operation;
  logic [IDX_W-1:0] entry_index;
  logic signed [VAL_W-1:0] log_prob_value;
  logic [SYM_W-1:0] symbol;
  logic last_symbol;
  modport source (output valid, operation, entry_index, log_prob_value, symbol, last_symbol,
                  input ready);
  modport sink (input valid, operation, entry_index, log_prob_value, symbol, last_symbol,
                output ready);
endinterface

interface hmmf_out_if import hmmf_pkg::*; ();
  logic valid, ready;
  logic signed [VAL_W-1:0] log_likelihood;
  logic likelihood_zero;
  modport source (output valid, log_likelihood, likelihood_zero, input ready);
  modport sink (input valid, log_likelihood, likelihood_zero, output ready);
endinterface

interface hmmf_cfg_if import hmmf_pkg::*; ();
  logic valid, ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/core/hmmf_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module hmmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/hmmf_datapath.sv
// Datapath: model tables, alpha vectors, one shared log-sum-exp accumulator.
// Depends on hmmf_pkg and hmmf_ram.
module hmmf_datapath import hmmf_pkg::*; #(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
  localparam int SW = $clog2(MAX_STATES),
  localparam int TW = $clog2(MAX_STATES * MAX_STATES),
  localparam int EW = $clog2(MAX_STATES * NUM_SYMBOLS)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [1:0]              wr_op,
  input  logic [IDX_W-1:0]        wr_idx,
  input  logic signed [VAL_W-1:0] wr_val,
  input  logic [SYM_W-1:0]        sym,
  input  logic [SW-1:0]           row_i,
  input  logic [SW-1:0]           col_j,
  input  dp_cmd_t                 cmd,
  output logic signed [VAL_W-1:0] out_val,
  output logic                    out_zero
);
  logic signed [VAL_W-1:0] init_q, trans_q, emit_q, emit_v;
  logic signed [VAL_W-1:0] alpha_cur_r [MAX_STATES];
  logic signed [VAL_W-1:0] alpha_prev_r [MAX_STATES];
  logic signed [VAL_W-1:0] acc_r, acc_nxt, opnd;
  logic signed [VAL_W-1:0] out_val_r;
  logic [SYM_W-1:0] sym_r;
  logic out_zero_r, sym_ok;
  logic we_i, we_t, we_e;
  logic [EW-1:0] e_raddr;

  assign we_i = wr_en && wr_op == OP_WR_INIT  && 32'(wr_idx) < MAX_STATES;
  assign we_t = wr_en && wr_op == OP_WR_TRANS && 32'(wr_idx) < MAX_STATES * MAX_STATES;
  assign we_e = wr_en && wr_op == OP_WR_EMIT  && 32'(wr_idx) < MAX_STATES * NUM_SYMBOLS;
  assign sym_ok = 32'(sym_r) < NUM_SYMBOLS;
  assign e_raddr = EW'(32'(row_i) * NUM_SYMBOLS + 32'(sym_r));

  hmmf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_STATES)) u_init (
    .clk, .we(we_i), .waddr(wr_idx[SW-1:0]), .wdata(wr_val), .raddr(row_i), .rdata(init_q));
  hmmf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_STATES * MAX_STATES)) u_trans (
    .clk, .we(we_t), .waddr(wr_idx[TW-1:0]), .wdata(wr_val),
    .raddr(TW'(32'(col_j) * MAX_STATES + 32'(row_i))), .rdata(trans_q));
  hmmf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_STATES * NUM_SYMBOLS)) u_emit (
    .clk, .we(we_e), .waddr(wr_idx[EW-1:0]), .wdata(wr_val), .raddr(e_raddr), .rdata(emit_q));

  // read addresses are held by the controller until the registered read data is used
  assign emit_v = sym_ok ? emit_q : LOG_ZERO;
  assign opnd = cmd.use_prod ? log_mul(alpha_prev_r[col_j], trans_q) : alpha_cur_r[row_i];
  assign acc_nxt = log_add(acc_r, opnd);

  always_ff @(posedge clk) begin
    if (cmd.ld_sym) sym_r <= sym;
    if (cmd.ld_acc) acc_r <= LOG_ZERO;
    else if (cmd.acc_step) acc_r <= acc_nxt;
    if (cmd.wr_first) alpha_cur_r[row_i] <= log_mul(init_q, emit_v);
    if (cmd.wr_alpha) alpha_cur_r[row_i] <= log_mul(acc_r, emit_v);
    if (cmd.copy_prev) alpha_prev_r <= alpha_cur_r;
    if (cmd.ld_out) begin
      out_zero_r <= acc_r == LOG_ZERO;
      out_val_r  <= (acc_r == LOG_ZERO) ? '0 : acc_r;
    end
  end
  assign out_val = out_val_r;
  assign out_zero = out_zero_r;
endmodule

### rtl/core/hmmf_ctrl.sv
// Controller: sequences table writes and the forward recursion.
// Depends on hmmf_pkg.
module hmmf_ctrl import hmmf_pkg::*; #(
  parameter int MAX_STATES = DEF_MAX_STATES,
  localparam int SW = $clog2(MAX_STATES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  input  logic             in_last,
  input  logic [CFG_W-1:0] n_cfg,
  output logic             wr_en,
  output logic [SW-1:0]    row_i,
  output logic [SW-1:0]    col_j,
  output dp_cmd_t          cmd,
  output logic             out_valid,
  input  logic             out_ready
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIRST = 7'b0000010,
    S_ROWST = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_WRA   = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [SW-1:0] i_r, i_nxt, j_r, j_nxt, last_idx;
  logic start_r, start_nxt, last_r, last_nxt, ov_r, ov_nxt, rd_r, rd_nxt;
  logic ld_out_r;
  logic accept;

  always_comb begin
    if (n_cfg == '0) last_idx = '0;
    else if (32'(n_cfg) > MAX_STATES) last_idx = SW'(MAX_STATES - 1);
    else last_idx = SW'(32'(n_cfg) - 1);
  end

  assign in_ready = state_r == S_IDLE && !ov_r && !ld_out_r;
  assign accept = in_valid && in_ready;
  assign wr_en = accept && in_op != OP_OBSERVE;
  assign row_i = i_r;
  assign col_j = j_r;
  assign out_valid = ov_r;

  // rd_r marks that the RAM read for the current address is available
  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; j_nxt = j_r;
    start_nxt = start_r; last_nxt = last_r;
    ov_nxt = ov_r && !out_ready;
    rd_nxt = 1'b0;
    cmd = '0;
    cmd.ld_out = ld_out_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_OBSERVE) begin
          cmd.ld_sym = 1'b1;
          last_nxt = in_last;
          i_nxt = '0; j_nxt = '0;
          if (start_r) state_nxt = S_FIRST;
          else begin
            cmd.copy_prev = 1'b1;
            state_nxt = S_ROWST;
          end
        end
      end
      S_FIRST: begin
        rd_nxt = 1'b1;
        if (rd_r) begin
          cmd.wr_first = 1'b1;
          rd_nxt = 1'b0;
          if (i_r == last_idx) state_nxt = S_SUM;
          else i_nxt = i_r + 1'b1;
        end
      end
      S_ROWST: begin
        cmd.ld_acc = 1'b1;
        j_nxt = '0;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        rd_nxt = 1'b1;
        if (rd_r) begin
          cmd.acc_step = 1'b1;
          cmd.use_prod = 1'b1;
          rd_nxt = 1'b0;
          if (j_r == last_idx) state_nxt = S_WRA;
          else j_nxt = j_r + 1'b1;
        end
      end
      S_WRA: begin
        rd_nxt = 1'b1;
        if (rd_r) begin
          cmd.wr_alpha = 1'b1;
          rd_nxt = 1'b0;
          if (i_r == last_idx) state_nxt = S_SUM;
          else begin
            i_nxt = i_r + 1'b1;
            state_nxt = S_ROWST;
          end
        end
      end
      S_SUM: begin
        if (!last_r) begin
          start_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          start_nxt = 1'b1;
          cmd.ld_acc = 1'b1;
          i_nxt = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.acc_step = 1'b1;
        if (i_r == last_idx) begin
          state_nxt = S_IDLE;
          cmd.acc_step = 1'b1;
        end else i_nxt = i_r + 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register loads in the cycle after the final sum step, via ld_out_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b1;
      ov_r <= 1'b0;
      rd_r <= 1'b0;
      ld_out_r <= 1'b0;
      last_r <= 1'b0;
      i_r <= '0;
      j_r <= '0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      rd_r <= rd_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      last_r <= last_nxt;
      ld_out_r <= state_r == S_OUT && i_r == last_idx;
      ov_r <= ld_out_r ? 1'b1 : ov_nxt;
    end
  end
endmodule

### rtl/core/hmm_forward_log_likelihood_unit.sv
// Log-domain HMM forward unit, top level.
// Depends on hmmf_pkg, hmmf_if, hmmf_ctrl, hmmf_datapath, hmmf_ram.
//
// Channels: in (operation, entry_index, log_prob_value, symbol, last_symbol),
// out (log_likelihood, likelihood_zero), cfg (states_in_use, 4 bits).
// All use valid/ready; a transfer happens when both are high at clk.
// Write items give no result.
// An observe item keeps the input blocked while it is processed: on the first
// symbol each state's alpha is written from init and emit; otherwise every
// log-sum-exp step is a RAM read, then the shared adder and correction
// lookup, plus row setup and alpha write per row.
// A last symbol adds a final sum over the states before out valid rises.
// A result waits in the output register; no item is accepted until it is
// taken, so a stalled receiver holds the block.
// Reset (rst_n low, synchronous) sets states_in_use to 8, marks the next
// symbol as first and drops out valid; table contents are undefined until
// written.
module hmm_forward_log_likelihood_unit import hmmf_pkg::*; #(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
  input logic clk,
  input logic rst_n,
  hmmf_in_if.sink   in_ch,
  hmmf_out_if.source out_ch,
  hmmf_cfg_if.sink  cfg_ch
);
  localparam int SW = $clog2(MAX_STATES);
  logic [CFG_W-1:0] n_r;
  logic wr_en;
  logic [SW-1:0] row_i, col_j;
  dp_cmd_t cmd;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) n_r <= CFG_W'(8);
    else if (cfg_ch.valid) n_r <= cfg_ch.data;
  end

  hmmf_ctrl #(.MAX_STATES(MAX_STATES)) u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.operation), .in_last(in_ch.last_symbol), .n_cfg(n_r),
    .wr_en, .row_i, .col_j, .cmd, .out_valid(out_ch.valid), .out_ready(out_ch.ready));

  hmmf_datapath #(.MAX_STATES(MAX_STATES), .NUM_SYMBOLS(NUM_SYMBOLS)) u_dp (
    .clk, .wr_en, .wr_op(in_ch.operation), .wr_idx(in_ch.entry_index),
    .wr_val(in_ch.log_prob_value), .sym(in_ch.symbol), .row_i, .col_j,
    .cmd(cmd), .out_val(out_ch.log_likelihood), .out_zero(out_ch.likelihood_zero));
endmodule
